@@ hdl/mft_pkg.sv @@
package mft_pkg;

	localparam int NUM_CHANNELS = 6;
	localparam int PIN_W        = 6;
	localparam int CH_W         = 3;
	localparam int COUNT_W      = 15;
	localparam int GATE_W       = 24;
	localparam int FILT_W       = 10;
	localparam int SCALE_W      = 8;
	localparam int RPM_W        = 23;
	localparam int CFG_DATA_W   = 24;
	localparam int CFG_IDX_W    = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;
	localparam logic [GATE_W-1:0]  GATE_RESET     = 24'd16000000;
	localparam logic [FILT_W-1:0]  FILTER_RESET   = 10'd1023;
	localparam logic [SCALE_W-1:0] SCALE_RESET    = 8'd150;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GATE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FILTER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd2;

	// closed window handed from the measurement stage to the output stage
	typedef struct packed {
		logic               valid;
		logic [CH_W-1:0]    ch;
		logic [COUNT_W-1:0] count;
	} mft_result_t;

endpackage

@@ hdl/multiplexed_fan_tachometer.sv @@
// A closed window is registered into the output buffer by the transaction that closes it.
// Throughput: one tach sample per cycle while in_ready is high; the filter, edge
// counter and gate timer all update in the cycle of the transaction. A two-entry
// output buffer holds results, so in_ready drops only when two results wait unread.
// Reset (arst_n low, asynchronous): channel 0, filtered level high, counters cleared,
// registers back to gate 16000000, filter 1023, scale 150.
module multiplexed_fan_tachometer
	import mft_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// sample channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [PIN_W-1:0]      tach_pins,
	// result channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [CH_W-1:0]       channel,
	output logic [COUNT_W-1:0]    pulse_count,
	output logic [RPM_W-1:0]      rpm,
	// configuration write port
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [GATE_W-1:0]  gate_ticks_q;
	logic [FILT_W-1:0]  filter_ticks_q;
	logic [SCALE_W-1:0] rpm_scale_q;

	logic        accept;
	mft_result_t res;

	// Hold the configuration; writes to an unused index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_ticks_q   <= GATE_RESET;
			filter_ticks_q <= FILTER_RESET;
			rpm_scale_q    <= SCALE_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_GATE:   gate_ticks_q   <= cfg_wdata[GATE_W-1:0];
				CFG_FILTER: filter_ticks_q <= cfg_wdata[FILT_W-1:0];
				CFG_SCALE:  rpm_scale_q    <= cfg_wdata[SCALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// A sample transaction advances the filter, the edge counter and the gate timer.
	assign accept = in_valid && in_ready;

	// Select the pin, glitch-filter it, count falling edges and time the window.
	mft_meas u_meas (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.tach_pins    (tach_pins),
		.gate_ticks   (gate_ticks_q),
		.filter_ticks (filter_ticks_q),
		.res          (res)
	);

	// Scale the count to rpm and buffer the result until it is taken.
	mft_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.res         (res),
		.rpm_scale   (rpm_scale_q),
		.in_ready    (in_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.channel     (channel),
		.pulse_count (pulse_count),
		.rpm         (rpm)
	);

endmodule

@@ hdl/mft_meas.sv @@
module mft_meas
	import mft_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [PIN_W-1:0]   tach_pins,
	input  logic [GATE_W-1:0]  gate_ticks,
	input  logic [FILT_W-1:0]  filter_ticks,
	output mft_result_t        res
);

	logic [CH_W-1:0]    ch_q;
	logic               level_q;
	logic [FILT_W-1:0]  run_q;
	logic [COUNT_W-1:0] count_q;
	logic [GATE_W-1:0]  elapsed_q;

	logic               pin;
	logic [FILT_W:0]    run_inc;
	logic               take;
	logic               level_d;
	logic [FILT_W-1:0]  run_d;
	logic [COUNT_W-1:0] count_d;
	logic [GATE_W-1:0]  elapsed_inc;
	logic               close;
	logic [CH_W:0]      ch_inc;
	logic [CH_W-1:0]    ch_next;

	always_comb begin
		pin = 1'b0;
		if (ch_q < CH_W'(PIN_W)) begin
			pin = tach_pins[ch_q];
		end
		run_inc = {1'b0, run_q} + 1'b1;
		take    = (pin != level_q) && (run_inc >= {1'b0, filter_ticks});
		level_d = level_q;
		run_d   = '0;
		count_d = count_q;
		if (pin != level_q) begin
			if (take) begin
				level_d = pin;
				if (!pin && (count_q != COUNT_MAX)) begin
					count_d = count_q + 1'b1;
				end
			end else begin
				run_d = run_inc[FILT_W-1:0];
			end
		end
		elapsed_inc = elapsed_q + 1'b1;
		close       = (elapsed_inc == '0) || (elapsed_inc >= gate_ticks);
		ch_inc      = {1'b0, ch_q} + 1'b1;
		ch_next     = (ch_inc >= (CH_W+1)'(NUM_CHANNELS)) ? '0 : ch_inc[CH_W-1:0];
	end

	assign res.valid = accept && close && (count_d != '0);
	assign res.ch    = ch_q;
	assign res.count = count_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q      <= '0;
			level_q   <= 1'b1;
			run_q     <= '0;
			count_q   <= '0;
			elapsed_q <= '0;
		end else if (accept) begin
			level_q <= level_d;
			run_q   <= run_d;
			if (close) begin
				ch_q      <= ch_next;
				count_q   <= '0;
				elapsed_q <= '0;
			end else begin
				count_q   <= count_d;
				elapsed_q <= elapsed_inc;
			end
		end
	end

endmodule

@@ hdl/mft_out.sv @@
module mft_out
	import mft_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  mft_result_t         res,
	input  logic [SCALE_W-1:0]  rpm_scale,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [CH_W-1:0]     channel,
	output logic [COUNT_W-1:0]  pulse_count,
	output logic [RPM_W-1:0]    rpm
);

	logic               out_valid_q;
	logic [CH_W-1:0]    ch_q;
	logic [COUNT_W-1:0] count_q;
	logic [RPM_W-1:0]   rpm_q;
	logic               skid_valid_q;
	logic [CH_W-1:0]    skid_ch_q;
	logic [COUNT_W-1:0] skid_count_q;
	logic [RPM_W-1:0]   skid_rpm_q;

	logic [RPM_W-1:0]   product;
	logic               slot_free;

	assign product   = RPM_W'(res.count) * RPM_W'(rpm_scale);
	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (res.valid) begin
				// skid is empty whenever a result can arrive
				if (slot_free) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (slot_free) begin
				out_valid_q  <= skid_valid_q;
				skid_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && slot_free) begin
			ch_q    <= res.ch;
			count_q <= res.count;
			rpm_q   <= product;
		end else if (slot_free && skid_valid_q) begin
			ch_q    <= skid_ch_q;
			count_q <= skid_count_q;
			rpm_q   <= skid_rpm_q;
		end
		if (res.valid && !slot_free) begin
			skid_ch_q    <= res.ch;
			skid_count_q <= res.count;
			skid_rpm_q   <= product;
		end
	end

	assign in_ready    = !skid_valid_q;
	assign out_valid   = out_valid_q;
	assign channel     = ch_q;
	assign pulse_count = count_q;
	assign rpm         = rpm_q;

endmodule

@@ hdl/mft_checker.sv @@
module mft_props
	import mft_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_ready,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [CH_W-1:0]       channel,
	input  logic [COUNT_W-1:0]    pulse_count,
	input  logic [RPM_W-1:0]      rpm
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(channel)
			&& $stable(pulse_count) && $stable(rpm))
		else $error("result changed while stalled");

	// empty windows give no result
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pulse_count != '0)
		else $error("result with zero count");

	a_channel_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> channel < CH_W'(NUM_CHANNELS))
		else $error("channel out of range");

	// input stalls only when a result is waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result pending");

endmodule

bind multiplexed_fan_tachometer mft_props u_mft_props (.*);

@@ verif/mft_checker.sv @@
`timescale 1ns / 100ps

module mft_checker
	import mft_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [PIN_W-1:0]      tach_pins,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [CH_W-1:0]       channel,
	input  logic [COUNT_W-1:0]    pulse_count,
	input  logic [RPM_W-1:0]      rpm,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int unsigned           mismatch_count,
	output int unsigned           windows_pending
);

	typedef struct packed {
		logic [CH_W-1:0]    ch;
		logic [COUNT_W-1:0] count;
		logic [RPM_W-1:0]   rpm;
	} window_t;

	window_t     windows_due [$];
	int unsigned fail_total = 0;
	int unsigned due_total  = 0;

	// register copies
	logic [GATE_W-1:0]  gate_len;
	logic [FILT_W-1:0]  filt_len;
	logic [SCALE_W-1:0] scale;

	// measurement state
	logic [CH_W-1:0]    scan_ch;
	logic               level_q;
	logic [FILT_W-1:0]  run_len;
	logic [COUNT_W-1:0] edges;
	logic [GATE_W-1:0]  elapsed;

	assign mismatch_count  = fail_total;
	assign windows_pending = due_total;

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		fail_total++;
	endtask

	// one tach sample: filter the selected pin, count falls, close the gate
	task automatic take_sample(input logic [PIN_W-1:0] pins);
		logic            level;
		logic [FILT_W:0] run_next;
		window_t         w;
		level = (int'(scan_ch) < PIN_W) ? pins[scan_ch] : 1'b0;
		if (level == level_q) begin
			run_len = '0;
		end else begin
			run_next = run_len + 1'b1;
			if (run_next >= filt_len) begin
				level_q = level;
				run_len = '0;
				if (!level && edges != COUNT_MAX)
					edges++;
			end else begin
				run_len = run_next[FILT_W-1:0];
			end
		end
		elapsed++;
		if (elapsed == '0 || elapsed >= gate_len) begin
			if (edges != '0) begin
				w.ch    = scan_ch;
				w.count = edges;
				w.rpm   = edges * scale;
				windows_due.push_back(w);
			end
			scan_ch = (int'(scan_ch) + 1 >= NUM_CHANNELS) ? '0 : scan_ch + 1'b1;
			edges   = '0;
			elapsed = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		window_t want;
		if (!arst_n) begin
			gate_len = GATE_RESET;
			filt_len = FILTER_RESET;
			scale    = SCALE_RESET;
			scan_ch  = '0;
			level_q  = 1'b1;
			run_len  = '0;
			edges    = '0;
			elapsed  = '0;
			windows_due.delete();
			due_total = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (windows_due.size() == 0) begin
					report_mismatch($sformatf("window with none pending: ch %0d count %0d rpm %0d",
						channel, pulse_count, rpm));
				end else begin
					want = windows_due.pop_front();
					if (channel !== want.ch)
						report_mismatch($sformatf("channel: got %0d, want %0d", channel, want.ch));
					if (pulse_count !== want.count)
						report_mismatch($sformatf("pulse_count on ch %0d: got %0d, want %0d",
							want.ch, pulse_count, want.count));
					if (rpm !== want.rpm)
						report_mismatch($sformatf("rpm on ch %0d: got %0d, want %0d",
							want.ch, rpm, want.rpm));
				end
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_GATE:   gate_len = cfg_wdata[GATE_W-1:0];
					CFG_FILTER: filt_len = cfg_wdata[FILT_W-1:0];
					CFG_SCALE:  scale    = cfg_wdata[SCALE_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				take_sample(tach_pins);
			due_total = windows_due.size();
		end
	end

endmodule

@@ verif/multiplexed_fan_tachometer_tb.sv @@
`timescale 1ns / 100ps

module multiplexed_fan_tachometer_tb;
	import mft_pkg::*;

	localparam int unsigned CYCLE_LIMIT    = 1000000;
	localparam int unsigned RANDOM_ITEMS   = 600;
	localparam int unsigned PRESSURE_HOLD  = 300;
	localparam int unsigned SETTLE_CYCLES  = 4;
	// index 3 has no register behind it; writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [PIN_W-1:0]      tach_pins;
	logic                  out_valid;
	logic                  out_ready;
	logic [CH_W-1:0]       channel;
	logic [COUNT_W-1:0]    pulse_count;
	logic [RPM_W-1:0]      rpm;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int unsigned mismatch_count;
	int unsigned windows_pending;
	int unsigned cycle_count;

	// quiet: no idling on either side; squeeze: ask the receiver for one long hold-off
	bit quiet;
	bit squeeze;

	multiplexed_fan_tachometer i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.tach_pins   (tach_pins),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.channel     (channel),
		.pulse_count (pulse_count),
		.rpm         (rpm),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata)
	);

	mft_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.tach_pins       (tach_pins),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.channel         (channel),
		.pulse_count     (pulse_count),
		.rpm             (rpm),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.mismatch_count  (mismatch_count),
		.windows_pending (windows_pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Mostly short idle stretches, now and then a long one.
	function automatic int unsigned idle_len();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return $urandom_range(1, 3);
		if (roll < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offer one sample transaction and hold it until accepted. Entered and left
	// at a falling edge; valid stays high into the next call unless a gap is chosen.
	task automatic send_sample(input logic [PIN_W-1:0] pins);
		int unsigned gap;
		gap = (quiet || $urandom_range(0, 1) == 0) ? 0 : idle_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		tach_pins <= pins;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// Drop valid, wait until every closed window has come out, then let SETTLE_CYCLES pass.
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (windows_pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write one register; bits above the register width carry junk on purpose.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		logic [CFG_DATA_W-1:0] junk;
		junk = CFG_DATA_W'($urandom);
		cfg_index <= idx;
		case (idx)
			CFG_GATE:   cfg_wdata <= value;
			CFG_FILTER: cfg_wdata <= {junk[CFG_DATA_W-1:FILT_W], value[FILT_W-1:0]};
			CFG_SCALE:  cfg_wdata <= {junk[CFG_DATA_W-1:SCALE_W], value[SCALE_W-1:0]};
			default:    cfg_wdata <= junk;
		endcase
		cfg_wr_en <= 1'b1;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Result side: random stalls, none while quiet, and one long hold-off per
	// squeeze request so the two-entry buffer fills and in_ready drops.
	initial begin : receiver
		int unsigned stall_left;
		bit          squeeze_done;
		stall_left   = 0;
		squeeze_done = 1'b0;
		out_ready    = 1'b0;
		forever begin
			@(negedge clk);
			if (squeeze && !squeeze_done) begin
				squeeze_done = 1'b1;
				out_ready <= 1'b0;
				for (int k = 0; k < PRESSURE_HOLD; k++)
					@(negedge clk);
				out_ready <= 1'b1;
			end else begin
				if (!squeeze)
					squeeze_done = 1'b0;
				if (quiet) begin
					stall_left = 0;
					out_ready <= 1'b1;
				end else if (stall_left != 0) begin
					stall_left--;
					out_ready <= 1'b0;
				end else if ($urandom_range(0, 3) == 0) begin
					stall_left = idle_len() - 1;
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b1;
				end
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("multiplexed_fan_tachometer: mismatch");
		$finish;
	end

	initial begin : stimulus
		logic [PIN_W-1:0] wave;
		logic [PIN_W-1:0] pins;
		int unsigned      hold_left [PIN_W];
		int unsigned      random_sent;
		int unsigned      phase_items;
		int unsigned      half_max;
		int unsigned      gate_pick;
		int unsigned      scale_pick;
		int unsigned      filt_now;
		bit               noisy;

		arst_n    = 1'b0;
		in_valid  = 1'b0;
		tach_pins = '0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Two samples under the reset registers: the long filter rejects nothing
		// here and the long gate keeps the window open.
		send_sample(6'h3F);
		send_sample(6'h3F);
		settle();

		// Short gate, filter off, full scale; the spare index must change nothing.
		write_reg(CFG_GATE, 24'd4);
		write_reg(CFG_FILTER, 24'd0);
		write_reg(CFG_SCALE, 24'd255);
		write_reg(CFG_SPARE, 24'd0);
		// ch0 closes with one fall, ch1 with two
		send_sample(6'h3F); send_sample(6'h00);
		send_sample(6'h3F); send_sample(6'h00); send_sample(6'h3F); send_sample(6'h00);
		// ch2 stays high: empty window, no result but the channel still advances
		send_sample(6'h3F); send_sample(6'h3F); send_sample(6'h3F); send_sample(6'h3F);
		// ch3 already low at the switch: one fall right away
		send_sample(6'h00); send_sample(6'h00); send_sample(6'h00); send_sample(6'h00);
		settle();

		// Gate of zero acts as one; zero scale gives rpm of zero.
		write_reg(CFG_GATE, 24'd0);
		write_reg(CFG_SCALE, 24'd0);
		send_sample(6'h3F); send_sample(6'h00); send_sample(6'h3F);
		settle();

		// Longest gate with filter of one, then cut the gate below the elapsed
		// count so the next sample closes the window.
		write_reg(CFG_GATE, 24'hFFFFFF);
		write_reg(CFG_FILTER, 24'd1);
		write_reg(CFG_SCALE, 24'd255);
		send_sample(6'h00); send_sample(6'h3F); send_sample(6'h00);
		settle();
		write_reg(CFG_GATE, 24'd2);
		send_sample(6'h3F); send_sample(6'h00);
		settle();

		// Long filter: a changed level is taken only after the full run, a
		// one-sample glitch restarts the run; the run survives channel switches.
		write_reg(CFG_FILTER, 24'd60);
		write_reg(CFG_GATE, 24'd50);
		write_reg(CFG_SCALE, CFG_DATA_W'(SCALE_RESET));
		repeat (40) send_sample(6'h3F);
		send_sample(6'h00);
		repeat (70) send_sample(6'h3F);
		repeat (70) send_sample(6'h00);
		settle();

		// Pressure: a window closes on every sample and the receiver holds off.
		random_sent = 0;
		squeeze = 1'b1;
		write_reg(CFG_GATE, 24'd1);
		write_reg(CFG_FILTER, 24'd0);
		filt_now = 0;
		repeat (60)
			send_sample(PIN_W'($urandom));
		random_sent += 60;
		settle();
		squeeze = 1'b0;

		// Random phases: tach-like square waves with random half periods around
		// the filter length, stray glitches, and now and then plain noise.
		wave = PIN_W'($urandom);
		while (random_sent < RANDOM_ITEMS) begin
			quiet = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 7))
					0:       gate_pick = 1;
					1:       gate_pick = $urandom_range(0, 3);
					2, 3, 4: gate_pick = $urandom_range(4, 16);
					5, 6:    gate_pick = $urandom_range(17, 64);
					default: gate_pick = $urandom_range(65, 200);
				endcase
				write_reg(CFG_GATE, CFG_DATA_W'(gate_pick));
			end
			if ($urandom_range(0, 3) != 0) begin
				filt_now = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 3);
				write_reg(CFG_FILTER, CFG_DATA_W'(filt_now));
			end
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 7))
					0:       scale_pick = 0;
					1:       scale_pick = 255;
					default: scale_pick = $urandom_range(0, 255);
				endcase
				write_reg(CFG_SCALE, CFG_DATA_W'(scale_pick));
			end
			if ($urandom_range(0, 7) == 0)
				write_reg(CFG_SPARE, CFG_DATA_W'($urandom));

			phase_items = $urandom_range(30, 120);
			noisy       = ($urandom_range(0, 4) == 0);
			half_max    = filt_now + $urandom_range(1, 8);
			for (int c = 0; c < PIN_W; c++)
				hold_left[c] = $urandom_range(1, half_max);
			repeat (phase_items) begin
				if (noisy) begin
					pins = PIN_W'($urandom);
				end else begin
					for (int c = 0; c < PIN_W; c++) begin
						hold_left[c]--;
						if (hold_left[c] == 0) begin
							wave[c]      = ~wave[c];
							hold_left[c] = $urandom_range(1, half_max);
						end
					end
					pins = wave;
					// flip one pin for a single sample now and then
					if ($urandom_range(0, 15) == 0)
						pins = pins ^ (PIN_W'(1) << $urandom_range(0, PIN_W - 1));
				end
				send_sample(pins);
			end
			random_sent += phase_items;
			settle();
		end
		quiet = 1'b0;

		if (mismatch_count == 0 && windows_pending == 0) begin
			$display("multiplexed_fan_tachometer: match");
		end else begin
			$display("multiplexed_fan_tachometer: mismatch");
		end
		$finish;
	end

endmodule
